FILE: design/gss_pkg.sv
// Shared types and constants of the gear shift sequencer.
`default_nettype none
package gss_pkg;

    localparam int GEAR_W   = 3;
    localparam int MS_W     = 16;
    localparam int NUM_LEN  = 8;
    localparam int IDX_W    = 3;
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 11;
    localparam int BYTE_W   = 8;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 24;

    localparam logic [MS_W-1:0]   LEN_RESET = 16'd500;
    localparam logic [MS_W-1:0]   MS_MAX    = 16'hFFFF;
    localparam logic [GEAR_W-1:0] GEAR_MIN  = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_MAX  = 3'd5;
    localparam logic [GEAR_W-1:0] GEAR_RST  = 3'd2;

    // event kinds
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FRAME = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CHAR  = 2'd2;

    localparam logic [ID_W-1:0] SELECTOR_ID = 11'h230;

    // selector codes
    localparam logic [BYTE_W-1:0] SEL_P  = 8'h08;
    localparam logic [BYTE_W-1:0] SEL_R  = 8'h07;
    localparam logic [BYTE_W-1:0] SEL_N  = 8'h06;
    localparam logic [BYTE_W-1:0] SEL_D  = 8'h05;
    localparam logic [BYTE_W-1:0] SEL_UP = 8'h09;
    localparam logic [BYTE_W-1:0] SEL_DN = 8'h0A;

    // console characters
    localparam logic [BYTE_W-1:0] CH_UP    = 8'h75;
    localparam logic [BYTE_W-1:0] CH_DN    = 8'h64;
    localparam logic [BYTE_W-1:0] CH_DUTY0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DUTY1 = 8'h31;
    localparam logic [BYTE_W-1:0] CH_DUTY2 = 8'h32;
    localparam logic [BYTE_W-1:0] CH_DUTY3 = 8'h33;

    localparam logic [BYTE_W-1:0] DUTY_0 = 8'd0;
    localparam logic [BYTE_W-1:0] DUTY_1 = 8'd64;
    localparam logic [BYTE_W-1:0] DUTY_2 = 8'd128;
    localparam logic [BYTE_W-1:0] DUTY_3 = 8'd249;

    typedef enum logic [1:0] {
        LEVER_P = 2'd0,
        LEVER_R = 2'd1,
        LEVER_N = 2'd2,
        LEVER_D = 2'd3
    } t_lever;

    typedef enum logic [1:0] {
        SOL_NONE  = 2'd0,
        SOL_12_45 = 2'd1,
        SOL_23    = 2'd2,
        SOL_34    = 2'd3
    } t_sol;

    typedef struct packed {
        logic [GEAR_W-1:0] gear_now;
        logic [GEAR_W-1:0] gear_target;
        logic              shifting;
        logic              sol_12_45;
        logic              sol_23;
        logic              sol_34;
        logic [1:0]        lever_position;
        logic [BYTE_W-1:0] clutch_duty;
        logic              shift_started;
        logic              shift_done;
    } t_result;

endpackage
`default_nettype wire

FILE: design/gss_regs.sv
// Pulse length register file, one entry per gear pair and direction.
`default_nettype none
module gss_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_we,
    input  wire logic [gss_pkg::IDX_W-1:0] i_wr_idx,
    input  wire logic [gss_pkg::MS_W-1:0]  i_wr_data,
    input  wire logic [gss_pkg::IDX_W-1:0] i_rd_idx,
    output logic      [gss_pkg::MS_W-1:0]  o_rd_data
);

    logic [gss_pkg::MS_W-1:0] r_len [gss_pkg::NUM_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gss_pkg::NUM_LEN; i++) begin
                r_len[i] <= gss_pkg::LEN_RESET;
            end
        end else if (i_we) begin
            r_len[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_len[i_rd_idx];

endmodule
`default_nettype wire

FILE: design/gss_core.sv
// Sequencer state and the per-event update logic.
`default_nettype none
module gss_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [gss_pkg::FUNC_W-1:0] i_func,
    input  wire logic [gss_pkg::ID_W-1:0]   i_can_id,
    input  wire logic [gss_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic [gss_pkg::BYTE_W-1:0] i_console_char,
    output logic      [gss_pkg::IDX_W-1:0]  o_len_idx,
    input  wire logic [gss_pkg::MS_W-1:0]   i_len,
    output gss_pkg::t_result                o_res
);

    logic [gss_pkg::GEAR_W-1:0] r_gear, n_gear;
    logic [gss_pkg::GEAR_W-1:0] r_target, n_target;
    logic                       r_active, n_active;
    logic [gss_pkg::MS_W-1:0]   r_elapsed, n_elapsed;
    logic [gss_pkg::MS_W-1:0]   r_pulse, n_pulse;
    gss_pkg::t_sol              r_sol, n_sol;
    gss_pkg::t_lever            r_lever, n_lever;
    logic [gss_pkg::BYTE_W-1:0] r_duty, n_duty;
    logic                       n_started, n_done;

    // shift request decode and the register index / solenoid of the move
    logic                       req_up, req_dn;
    logic [gss_pkg::GEAR_W-1:0] gear_m1, gear_m2;
    logic [1:0]                 pair;
    logic                       is_frame;

    always_comb begin
        n_gear    = r_gear;
        n_target  = r_target;
        n_active  = r_active;
        n_elapsed = r_elapsed;
        n_pulse   = r_pulse;
        n_sol     = r_sol;
        n_lever   = r_lever;
        n_duty    = r_duty;
        n_done    = 1'b0;
        req_up    = 1'b0;
        req_dn    = 1'b0;

        if (i_func == gss_pkg::FN_TICK && r_elapsed != gss_pkg::MS_MAX) begin
            n_elapsed = r_elapsed + 1'b1;
        end

        if (r_active && n_elapsed >= r_pulse) begin
            n_sol    = gss_pkg::SOL_NONE;
            n_gear   = r_target;
            n_active = 1'b0;
            n_done   = 1'b1;
        end

        is_frame = (i_func == gss_pkg::FN_FRAME) && (i_can_id == gss_pkg::SELECTOR_ID);
        if (is_frame) begin
            priority if (i_data_byte == gss_pkg::SEL_P) begin
                n_lever = gss_pkg::LEVER_P;
            end else if (i_data_byte == gss_pkg::SEL_R) begin
                n_lever = gss_pkg::LEVER_R;
            end else if (i_data_byte == gss_pkg::SEL_N) begin
                n_lever = gss_pkg::LEVER_N;
            end else if (i_data_byte == gss_pkg::SEL_D) begin
                n_lever = gss_pkg::LEVER_D;
            end else if (i_data_byte == gss_pkg::SEL_UP) begin
                req_up = (r_lever == gss_pkg::LEVER_D) && (n_gear < gss_pkg::GEAR_MAX);
            end else if (i_data_byte == gss_pkg::SEL_DN) begin
                req_dn = (r_lever == gss_pkg::LEVER_D) && (n_gear > gss_pkg::GEAR_MIN);
            end else begin
            end
        end else if (i_func == gss_pkg::FN_CHAR) begin
            priority if (i_console_char == gss_pkg::CH_UP) begin
                req_up = n_gear < gss_pkg::GEAR_MAX;
            end else if (i_console_char == gss_pkg::CH_DN) begin
                req_dn = n_gear > gss_pkg::GEAR_MIN;
            end else if (i_console_char == gss_pkg::CH_DUTY0) begin
                n_duty = gss_pkg::DUTY_0;
            end else if (i_console_char == gss_pkg::CH_DUTY1) begin
                n_duty = gss_pkg::DUTY_1;
            end else if (i_console_char == gss_pkg::CH_DUTY2) begin
                n_duty = gss_pkg::DUTY_2;
            end else if (i_console_char == gss_pkg::CH_DUTY3) begin
                n_duty = gss_pkg::DUTY_3;
            end else begin
            end
        end

        // pair number is the lower gear minus one
        gear_m1 = n_gear - 3'd1;
        gear_m2 = n_gear - 3'd2;
        pair    = req_up ? gear_m1[1:0] : gear_m2[1:0];
        o_len_idx = {pair, ~req_up};

        n_started = (req_up || req_dn) && !n_active;
        if (n_started) begin
            n_target  = req_up ? n_gear + 3'd1 : gear_m1;
            n_active  = 1'b1;
            n_elapsed = '0;
            n_pulse   = i_len;
            unique case (pair)
                2'd1:    n_sol = gss_pkg::SOL_23;
                2'd2:    n_sol = gss_pkg::SOL_34;
                default: n_sol = gss_pkg::SOL_12_45;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gear    <= gss_pkg::GEAR_RST;
            r_target  <= '0;
            r_active  <= 1'b0;
            r_elapsed <= '0;
            r_pulse   <= gss_pkg::LEN_RESET;
            r_sol     <= gss_pkg::SOL_NONE;
            r_lever   <= gss_pkg::LEVER_P;
            r_duty    <= '0;
        end else if (i_step) begin
            r_gear    <= n_gear;
            r_target  <= n_target;
            r_active  <= n_active;
            r_elapsed <= n_elapsed;
            r_pulse   <= n_pulse;
            r_sol     <= n_sol;
            r_lever   <= n_lever;
            r_duty    <= n_duty;
        end
    end

    always_comb begin
        o_res.gear_now       = n_gear;
        o_res.gear_target    = n_target;
        o_res.shifting       = n_active;
        o_res.sol_12_45      = (n_sol == gss_pkg::SOL_12_45);
        o_res.sol_23         = (n_sol == gss_pkg::SOL_23);
        o_res.sol_34         = (n_sol == gss_pkg::SOL_34);
        o_res.lever_position = n_lever;
        o_res.clutch_duty    = n_duty;
        o_res.shift_started  = n_started;
        o_res.shift_done     = n_done;
    end

    a_active_sol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_sol != gss_pkg::SOL_NONE))
        else $error("shift flag and solenoid drive disagree");

    a_gear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gear >= gss_pkg::GEAR_MIN && r_gear <= gss_pkg::GEAR_MAX)
        else $error("engaged gear out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_started |=> r_active && r_elapsed == '0 && r_target != '0)
        else $error("started shift not armed");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_done && !n_started |=> !r_active && r_gear == $past(r_target))
        else $error("finished shift did not engage target gear");

endmodule
`default_nettype wire

FILE: design/gear_shift_sequencer.sv
// Gear shift sequencer top level: stream ports, input and result registers.
// Path: an accepted item is held in the input register and moves into the result
//   register when the result slot is free or being emptied, then offered on m_axis.
// Throughput: one item per cycle while results are taken; the per-item update is one
//   shallow pass between the input register and the result register.
// Reset: synchronous, active low; gear 2, lever P, duty 0, all pulse lengths 500.
`default_nettype none
module gear_shift_sequencer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config write port, index = register position
    input  wire logic                        i_cfg_we,
    input  wire logic [gss_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [gss_pkg::MS_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [10:0] can_id, [18:11] data_byte, [26:19] console_char, [31:27] zero
    input  wire logic [gss_pkg::IN_W-1:0]    s_axis_tdata,
    // [1:0] func
    input  wire logic [gss_pkg::FUNC_W-1:0]  s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [2:0] gear_now, [5:3] gear_target, [6] shifting, [7] sol_12_45,
    // [8] sol_23, [9] sol_34, [11:10] lever_position, [19:12] clutch_duty,
    // [20] shift_started, [21] shift_done, [23:22] zero
    output logic      [gss_pkg::OUT_W-1:0]   m_axis_tdata
);

    // input register
    logic                         r_in_valid;
    logic [gss_pkg::FUNC_W-1:0]   r_func;
    logic [gss_pkg::ID_W-1:0]     r_can_id;
    logic [gss_pkg::BYTE_W-1:0]   r_data_byte;
    logic [gss_pkg::BYTE_W-1:0]   r_console_char;

    // result register
    logic                         r_out_valid;
    gss_pkg::t_result             r_res;

    logic                         in_fire;
    logic                         step;
    logic [gss_pkg::IDX_W-1:0]    len_idx;
    logic [gss_pkg::MS_W-1:0]     len;
    gss_pkg::t_result             res;

    // An item moves from the input register into the result register when the
    // result slot is free or is being emptied this cycle.
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func         <= s_axis_tuser;
            r_can_id       <= s_axis_tdata[10:0];
            r_data_byte    <= s_axis_tdata[18:11];
            r_console_char <= s_axis_tdata[26:19];
        end
    end

    gss_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_wr_idx  (i_cfg_idx),
        .i_wr_data (i_cfg_data),
        .i_rd_idx  (len_idx),
        .o_rd_data (len)
    );

    // State advances exactly once per item, on the step into the result slot.
    gss_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_func         (r_func),
        .i_can_id       (r_can_id),
        .i_data_byte    (r_data_byte),
        .i_console_char (r_console_char),
        .o_len_idx      (len_idx),
        .i_len          (len),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_res.shift_done,
                            r_res.shift_started,
                            r_res.clutch_duty,
                            r_res.lever_position,
                            r_res.sol_34,
                            r_res.sol_23,
                            r_res.sol_12_45,
                            r_res.shifting,
                            r_res.gear_target,
                            r_res.gear_now};

endmodule
`default_nettype wire

FILE: sim/gss_result_checker.sv
// Result checker for the gear shift sequencer: mirrors the block and compares its result items.
`timescale 1ns / 100ps
module gss_result_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gss_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gss_pkg::MS_W-1:0]     i_cfg_data,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    // [10:0] can_id, [18:11] data_byte, [26:19] console_char, [31:27] zero
    input  wire logic [gss_pkg::IN_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  wire logic [gss_pkg::FUNC_W-1:0]   s_axis_tuser,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [2:0] gear_now, [5:3] gear_target, [6] shifting, [7] sol_12_45,
    // [8] sol_23, [9] sol_34, [11:10] lever_position, [19:12] clutch_duty,
    // [20] shift_started, [21] shift_done, [23:22] zero
    input  wire logic [gss_pkg::OUT_W-1:0]    m_axis_tdata,
    output int                                o_fail_count,
    output int                                o_item_count,
    output int                                o_result_count,
    output int                                o_shift_count
);
    import gss_pkg::*;

    // mirrored block state
    logic [MS_W-1:0]   pulse_cfg [NUM_LEN];
    logic [GEAR_W-1:0] gear_m;
    logic [GEAR_W-1:0] target_m;
    logic              busy_m;
    logic [MS_W-1:0]   elapsed_m;
    logic [MS_W-1:0]   len_m;
    t_sol              sol_m;
    t_lever            lever_m;
    logic [BYTE_W-1:0] duty_m;

    t_result expected_results [$];
    int fail_n     = 0;
    int accepted_n = 0;
    int results_n  = 0;
    int started_n  = 0;

    assign o_fail_count   = fail_n;
    assign o_item_count   = accepted_n;
    assign o_result_count = results_n;
    assign o_shift_count  = started_n;

    // one-gear shift; caller has already checked the gear limit
    task automatic begin_shift(input logic up, output logic began);
        logic [GEAR_W-1:0] next_gear;
        logic [IDX_W-1:0]  idx;
        began = 1'b0;
        if (!busy_m) begin
            next_gear = up ? gear_m + 3'd1 : gear_m - 3'd1;
            if (next_gear >= GEAR_MIN && next_gear <= GEAR_MAX) begin
                // register pair of lower gear L: 2*(L-1), odd index for downshift
                idx = up ? IDX_W'((gear_m - 3'd1) * 2) : IDX_W'((next_gear - 3'd1) * 2 + 1);
                case (idx[2:1])
                    2'd1:    sol_m = SOL_23;
                    2'd2:    sol_m = SOL_34;
                    default: sol_m = SOL_12_45;
                endcase
                target_m  = next_gear;
                busy_m    = 1'b1;
                elapsed_m = '0;
                len_m     = pulse_cfg[idx];
                began     = 1'b1;
            end
        end
    endtask

    task automatic predict_event(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                                 input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] ch,
                                 output t_result res);
        logic began;
        logic ended;
        began = 1'b0;
        ended = 1'b0;
        if (fn == FN_TICK && elapsed_m != MS_MAX)
            elapsed_m = elapsed_m + 16'd1;
        if (busy_m && elapsed_m >= len_m) begin
            sol_m  = SOL_NONE;
            gear_m = target_m;
            busy_m = 1'b0;
            ended  = 1'b1;
        end
        if (fn == FN_FRAME && id == SELECTOR_ID) begin
            case (code)
                SEL_P:   lever_m = LEVER_P;
                SEL_R:   lever_m = LEVER_R;
                SEL_N:   lever_m = LEVER_N;
                SEL_D:   lever_m = LEVER_D;
                SEL_UP:  if (lever_m == LEVER_D && gear_m < GEAR_MAX) begin_shift(1'b1, began);
                SEL_DN:  if (lever_m == LEVER_D && gear_m > GEAR_MIN) begin_shift(1'b0, began);
                default: ;
            endcase
        end else if (fn == FN_CHAR) begin
            case (ch)
                CH_UP:    if (gear_m < GEAR_MAX) begin_shift(1'b1, began);
                CH_DN:    if (gear_m > GEAR_MIN) begin_shift(1'b0, began);
                CH_DUTY0: duty_m = DUTY_0;
                CH_DUTY1: duty_m = DUTY_1;
                CH_DUTY2: duty_m = DUTY_2;
                CH_DUTY3: duty_m = DUTY_3;
                default:  ;
            endcase
        end
        res.gear_now       = gear_m;
        res.gear_target    = target_m;
        res.shifting       = busy_m;
        res.sol_12_45      = (sol_m == SOL_12_45);
        res.sol_23         = (sol_m == SOL_23);
        res.sol_34         = (sol_m == SOL_34);
        res.lever_position = lever_m;
        res.clutch_duty    = duty_m;
        res.shift_started  = began;
        res.shift_done     = ended;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            fail_n++;
            if (fail_n <= 10)
                $display("%0t: result %0d, %s: expected %0d, got %0d",
                         $time, results_n, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEN; i++)
                pulse_cfg[i] = LEN_RESET;
            gear_m    = GEAR_RST;
            target_m  = '0;
            busy_m    = 1'b0;
            elapsed_m = '0;
            len_m     = LEN_RESET;
            sol_m     = SOL_NONE;
            lever_m   = LEVER_P;
            duty_m    = DUTY_0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                pulse_cfg[i_cfg_idx] = i_cfg_data;
            // retire first, so a result can never match the item taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.gear_now       = m_axis_tdata[2:0];
                got.gear_target    = m_axis_tdata[5:3];
                got.shifting       = m_axis_tdata[6];
                got.sol_12_45      = m_axis_tdata[7];
                got.sol_23         = m_axis_tdata[8];
                got.sol_34         = m_axis_tdata[9];
                got.lever_position = m_axis_tdata[11:10];
                got.clutch_duty    = m_axis_tdata[19:12];
                got.shift_started  = m_axis_tdata[20];
                got.shift_done     = m_axis_tdata[21];
                if (expected_results.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: result item with none outstanding: %h",
                                 $time, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("gear_now", want.gear_now, got.gear_now);
                    compare_field("gear_target", want.gear_target, got.gear_target);
                    compare_field("shifting", want.shifting, got.shifting);
                    compare_field("sol_12_45", want.sol_12_45, got.sol_12_45);
                    compare_field("sol_23", want.sol_23, got.sol_23);
                    compare_field("sol_34", want.sol_34, got.sol_34);
                    compare_field("lever_position", want.lever_position, got.lever_position);
                    compare_field("clutch_duty", want.clutch_duty, got.clutch_duty);
                    compare_field("shift_started", want.shift_started, got.shift_started);
                    compare_field("shift_done", want.shift_done, got.shift_done);
                    compare_field("padding bits", 0, m_axis_tdata[23:22]);
                end
                results_n <= results_n + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_event(s_axis_tuser,
                              s_axis_tdata[ID_W-1:0],
                              s_axis_tdata[ID_W+BYTE_W-1:ID_W],
                              s_axis_tdata[ID_W+2*BYTE_W-1:ID_W+BYTE_W],
                              want);
                expected_results.push_back(want);
                accepted_n <= accepted_n + 1;
                if (want.shift_started)
                    started_n <= started_n + 1;
            end
        end
    end

endmodule

FILE: sim/gear_shift_sequencer_tb.sv
// Testbench top for the gear shift sequencer: stimulus, config writes and verdict.
`timescale 1ns / 100ps
module gear_shift_sequencer_tb;
    import gss_pkg::*;

    // event kind 3 is no event at all; only the completion check runs
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
    localparam int ITEMS_PER_PHASE = 350;   // four random phases
    localparam int SETTLE_CYCLES   = 4;     // margin after the last result is back
    localparam int LONG_LEN        = 48;    // pulse length of the long-pulse test
    localparam int LONG_TICKS      = 50;    // a little past the end of that pulse
    localparam int FILL_W          = IN_W - ID_W - 2 * BYTE_W;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]    i_cfg_idx     = '0;
    logic [MS_W-1:0]     i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    wire logic           s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic [FUNC_W-1:0]   s_axis_tuser  = FN_TICK;
    wire logic           m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire logic [OUT_W-1:0] m_axis_tdata;

    int fail_count;
    int item_count;
    int result_count;
    int shift_count;
    int pending;

    // idle percentages of the current phase
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    logic [MS_W-1:0] lens [NUM_LEN];

    gear_shift_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gss_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_item_count   (item_count),
        .o_result_count (result_count),
        .o_shift_count  (shift_count)
    );

    // counters move on nonblocking updates, so this reads stable right after an edge
    assign pending = item_count - result_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls at the phase's rate, none when the rate is zero
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // one item; random sender gaps first, valid held high between back-to-back items
    task automatic send_event(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                              input logic [BYTE_W-1:0] code, input logic [BYTE_W-1:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, ch, code, id};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] code);
        send_event(FN_FRAME, SELECTOR_ID, code, BYTE_W'($urandom_range(255)));
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] ch);
        send_event(FN_CHAR, ID_W'($urandom_range(2047)), BYTE_W'($urandom_range(255)), ch);
    endtask

    task automatic send_tick();
        send_event(FN_TICK, ID_W'($urandom_range(2047)), BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)));
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all eight pulse lengths; only called with the block idle
    task automatic program_lengths();
        for (int i = 0; i < NUM_LEN; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IDX_W'(i);
            i_cfg_data <= lens[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed selector traffic and console commands, some noise
    task automatic random_event();
        int unsigned pick;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] ch;
        pick = $urandom_range(99);
        if (pick < 38) begin
            send_tick();
        end else if (pick < 63) begin
            case ($urandom_range(9))
                0:       code = SEL_P;
                1:       code = SEL_R;
                2:       code = SEL_N;
                3, 4:    code = SEL_D;
                5, 6, 7: code = SEL_UP;
                default: code = SEL_DN;
            endcase
            send_frame(code);
        end else if (pick < 68) begin
            // foreign frames and junk selector codes
            send_event(FN_FRAME,
                       $urandom_range(1) ? SELECTOR_ID : ID_W'($urandom_range(2047)),
                       BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end else if (pick < 88) begin
            case ($urandom_range(7))
                0, 1:    ch = CH_UP;
                2, 3:    ch = CH_DN;
                4:       ch = CH_DUTY0;
                5:       ch = CH_DUTY1;
                6:       ch = CH_DUTY2;
                default: ch = CH_DUTY3;
            endcase
            send_char(ch);
        end else if (pick < 93) begin
            send_char(BYTE_W'($urandom_range(255)));
        end else begin
            send_event(FN_NONE, ID_W'($urandom_range(2047)), BYTE_W'($urandom_range(255)),
                       BYTE_W'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        int max_len [4];
        int tx_pct [4];
        int rx_pct [4];
        max_len = '{3, 8, 1, 12};
        tx_pct  = '{0, 51, 0, 9};
        rx_pct  = '{0, 0, 51, 9};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset pulse lengths: lever codes, duty codes, ignored events
        send_event(FN_NONE, ID_W'($urandom_range(2047)), 8'hFF, 8'hFF);
        send_event(FN_FRAME, SELECTOR_ID + 11'd1, SEL_D, 8'h00);  // foreign identifier
        send_frame(8'hFF);                                        // unknown selector code
        send_frame(SEL_UP);                                       // up request in park
        send_char(CH_DUTY3);
        send_char(CH_DUTY1);
        send_char(CH_DUTY2);
        send_char(CH_DUTY0);
        send_char(8'hFF);                                         // unknown character
        send_frame(SEL_R);
        send_frame(SEL_N);
        send_frame(SEL_P);
        send_frame(SEL_D);
        wait_for_results();

        // zero-length pulses everywhere except 2->3, which takes one tick
        foreach (lens[i])
            lens[i] = '0;
        lens[2] = 16'd1;
        program_lengths();
        send_frame(SEL_UP);     // 2->3 starts
        send_frame(SEL_DN);     // ignored while shifting
        send_tick();            // 2->3 done
        send_frame(SEL_UP);     // 3->4, zero length
        send_char(CH_UP);       // 3->4 done and 4->5 starts in one item
        send_tick();            // into gear 5
        send_char(CH_UP);       // top gear, ignored
        send_char(CH_DN);       // 5->4
        send_frame(SEL_DN);     // done plus 4->3
        send_frame(SEL_N);      // done, lever to neutral
        send_frame(SEL_DN);     // not in drive, ignored
        send_char(CH_DN);       // console ignores the lever: 3->2
        send_char(CH_DN);       // done plus 2->1
        send_tick();            // into gear 1
        send_char(CH_DN);       // bottom gear, ignored
        wait_for_results();

        // longer pulse: completes on its last tick, then further ticks follow
        foreach (lens[i])
            lens[i] = MS_W'(LONG_LEN);
        program_lengths();
        send_char(CH_UP);
        repeat (LONG_TICKS)
            send_tick();
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            foreach (lens[i])
                lens[i] = MS_W'($urandom_range(max_len[phase]));
            program_lengths();
            tx_idle_pct  = tx_pct[phase];
            rx_stall_pct = rx_pct[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_event();
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end

        $display("Ran %0d items (%0d back-to-back ticks on a %0d ms pulse), %0d shifts started.",
                 item_count, LONG_TICKS, LONG_LEN, shift_count);
        $display("Checked %0d results over four idle/stall mixes with short pulse lengths.",
                 result_count);
        if (fail_count == 0) begin
            $display("gear_shift_sequencer regression: pass");
        end else begin
            $display("gear_shift_sequencer regression: fail");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("gear_shift_sequencer regression: fail");
        $finish;
    end

endmodule
